[rtl/spwp_pkg.sv]
package spwp_pkg;

    // phase count and field widths
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_W     = 3;
    localparam int LENGTH_W    = 4;
    localparam int SCAN_LEN    = 2 * PHASE_COUNT;
    localparam int SCAN_IDX_W  = $clog2(SCAN_LEN);
    localparam int RUN_W       = $clog2(SCAN_LEN + 1);

    typedef logic [PHASE_W-1:0]     t_phase;
    typedef logic [LENGTH_W-1:0]    t_length;
    typedef logic [PHASE_COUNT-1:0] t_mask;

    // one candidate run: its length and the scan step where it ends
    typedef struct packed {
        logic [RUN_W-1:0]      run;
        logic [SCAN_IDX_W-1:0] idx;
    } t_cand;

    // earlier candidate wins a tie
    function automatic t_cand pick_longer(input t_cand a, input t_cand b);
        t_cand r;
        r = (a.run >= b.run) ? a : b;
        return r;
    endfunction

endpackage

[rtl/sample_phase_window_picker.sv]
// sample phase window picker
//
// Command port: a pass mask beat is taken on a rising edge where start is
// high and busy is low. busy never rises, so a new mask can be given in
// every cycle and the block sustains one mask per clock.
// Result port: o_strobe is high for exactly one cycle with o_chosen_phase
// and o_window_length; the receiver cannot hold it off and need not.
// A mask passes through one input register and one result register; the
// run search over the doubled mask is a single combinational pass between
// them.
// Configuration port: i_cfg_valid/o_cfg_ready write current_phase; ready is
// always high. Write it only while no mask is in flight.
// Reset (synchronous, active low) clears the pipeline valid flags and sets
// current_phase to 0; no result is shown until a new mask is taken.
module sample_phase_window_picker (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  spwp_pkg::t_mask        i_pass_mask,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  spwp_pkg::t_phase       i_cfg_current_phase,
    output logic                   o_strobe,
    output spwp_pkg::t_phase       o_chosen_phase,
    output spwp_pkg::t_length      o_window_length
);
    import spwp_pkg::*;

    t_phase  r_cur;
    logic    r_in_valid;
    t_mask   r_mask;
    logic    r_out_valid;
    t_phase  r_out_phase;
    t_length r_out_len;

    logic [SCAN_LEN-1:0]     dbl;
    t_cand                   lvl0 [SCAN_LEN];
    t_cand                   lvl1 [SCAN_LEN/2];
    t_cand                   lvl2 [SCAN_LEN/4];
    t_cand                   lvl3 [SCAN_LEN/8];
    t_cand                   best;
    logic [SCAN_IDX_W:0]     centre;
    logic [SCAN_IDX_W:0]     centre_mod;
    t_phase                  n_phase;
    t_length                 n_len;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cur <= i_cfg_current_phase;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_mask <= i_pass_mask;
        end
    end

    // run length ending at each step of the mask taken twice around
    always_comb begin
        logic             alive;
        logic [RUN_W-1:0] run;
        dbl = {r_mask, r_mask};
        for (int i = 0; i < SCAN_LEN; i++) begin
            alive = 1'b1;
            run   = '0;
            for (int j = 0; j < SCAN_LEN; j++) begin
                if (j <= i) begin
                    if (alive && dbl[i-j]) begin
                        run = run + RUN_W'(1);
                    end else begin
                        alive = 1'b0;
                    end
                end
            end
            lvl0[i].run = run;
            lvl0[i].idx = SCAN_IDX_W'(i);
        end
    end

    // longest run, earliest on a tie
    always_comb begin
        for (int i = 0; i < SCAN_LEN/2; i++) begin
            lvl1[i] = pick_longer(lvl0[2*i], lvl0[2*i+1]);
        end
        for (int i = 0; i < SCAN_LEN/4; i++) begin
            lvl2[i] = pick_longer(lvl1[2*i], lvl1[2*i+1]);
        end
        for (int i = 0; i < SCAN_LEN/8; i++) begin
            lvl3[i] = pick_longer(lvl2[2*i], lvl2[2*i+1]);
        end
        best = pick_longer(lvl3[0], lvl3[1]);
    end

    // centre of the run, folded back into the phase range; an all-fail or all-pass mask keeps the current phase
    always_comb begin
        centre = {1'b0, best.idx} - (SCAN_IDX_W+1)'(best.run >> 1);
        if (centre >= (SCAN_IDX_W+1)'(PHASE_COUNT)) begin
            centre_mod = centre - (SCAN_IDX_W+1)'(PHASE_COUNT);
        end else begin
            centre_mod = centre;
        end
        if (r_mask == '0) begin
            n_phase = r_cur;
            n_len   = '0;
        end else if (r_mask == '1) begin
            n_phase = r_cur;
            n_len   = LENGTH_W'(PHASE_COUNT);
        end else begin
            n_phase = centre_mod[PHASE_W-1:0];
            n_len   = best.run[LENGTH_W-1:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_phase <= n_phase;
            r_out_len   <= n_len;
        end
    end

    assign o_strobe        = r_out_valid;
    assign o_chosen_phase  = r_out_phase;
    assign o_window_length = r_out_len;

`ifndef NO_ASSERTIONS
    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("accepted mask gave no result");

    a_result_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, 2))
        else $error("result without an accepted mask");

    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_window_length <= LENGTH_W'(PHASE_COUNT)))
        else $error("window length out of range");

    a_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_window_length == LENGTH_W'(PHASE_COUNT)) |->
            ($past(i_pass_mask, 2) == '1))
        else $error("full window for a mask with a failing phase");
`endif

endmodule
